/* rtl/chce_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Cubic Hermite curve evaluator: shared package
// Types, codes and small helper functions used across the curve evaluator.
// ----------------------------------------------------------------------------
package chce_pkg;

   // Default depth of the control point table.
   localparam int MaxPointsDefault = 16;

   // Item kinds carried on the request tuser.
   localparam logic ModeWrite = 1'b0;
   localparam logic ModeEval  = 1'b1;

   // Result status codes carried on the response tuser.
   localparam logic [1:0] StatusEval  = 2'd0;
   localparam logic [1:0] StatusShort = 2'd1;
   localparam logic [1:0] StatusWrite = 2'd2;

   // Width of one stored control point.
   localparam int PointWidth = 192;

   // One control point: position and tangent, all signed Q16.16.
   typedef struct packed {
      logic signed [31:0] tan_z;
      logic signed [31:0] tan_y;
      logic signed [31:0] tan_x;
      logic signed [31:0] pos_z;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_x;
   } point_type;

   // Hermite basis weights, signed Q16 with headroom.
   typedef struct packed {
      logic signed [19:0] h00;
      logic signed [19:0] h01;
      logic signed [19:0] h10;
      logic signed [19:0] h11;
   } basis_type;

   // Control word handed from the front end to the blend stages.
   typedef struct packed {
      logic       valid;
      logic [1:0] status;
      basis_type  basis;
   } side_type;

   // One restoring remainder step: shift in a dividend bit and subtract
   // the divisor when it fits.
   function automatic logic [7:0] seg_step(input logic [7:0] rem,
                                           input logic       bit_in,
                                           input logic [7:0] divisor);
      logic [8:0] acc;
      acc = {rem, bit_in};
      if (acc >= {1'b0, divisor}) begin
         acc = acc - {1'b0, divisor};
      end
      return acc[7:0];
   endfunction

endpackage
`default_nettype wire

/* rtl/cubic_hermite_curve_eval.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Cubic Hermite curve evaluator
// Stores control points and evaluates the Hermite blend between neighbours.
// ----------------------------------------------------------------------------
// The block takes one transfer per cycle and returns one result for each,
// in order; seven register stages (four front stages for segment remainder
// and basis, the table read, the products, the sum into the response
// register) lie between a transfer and its result, and the whole pipeline
// holds while a result waits on rsp_tready. A write
// transfer stores its point when it reaches the table stage, so any later
// evaluation sees it. Table entries are not cleared by reset and have no
// clearing pass: every entry an evaluation touches must have been written
// first. csr_wdata sets the number of points in use and may change only while
// the pipeline is empty.
module cubic_hermite_curve_eval #(
   parameter int MAX_POINTS = chce_pkg::MaxPointsDefault
) (
   input  wire logic         clock,
   input  wire logic         reset,
   // Request channel.
   input  wire logic         req_tvalid,
   output      logic         req_tready,
   input  wire logic [223:0] req_tdata,  // slot, pos_x, pos_y, pos_z, tan_x, tan_y,
                                         // tan_z, curve_time, zero fill
   input  wire logic         req_tuser,  // mode
   // Response channel.
   output      logic         rsp_tvalid,
   input  wire logic         rsp_tready,
   output      logic [95:0]  rsp_tdata,  // out_x, out_y, out_z
   output      logic [1:0]   rsp_tuser,  // status
   // Configuration.
   input  wire logic         csr_we,
   input  wire logic [4:0]   csr_wdata
);

   localparam int AddrWidth = $clog2(MAX_POINTS);

   logic [4:0]           points_in_use_ff, points_in_use_in;
   logic [8:0]           n_ext, n_eff;
   logic                 short_curve;
   logic [7:0]           divisor;
   logic                 ce;

   chce_pkg::point_type  in_entry;
   logic                 f_valid;
   logic                 f_mode;
   logic [3:0]           f_slot;
   chce_pkg::point_type  f_entry;
   chce_pkg::basis_type  f_basis;
   logic [7:0]           seg_rem;

   logic [AddrWidth-1:0] addr_a, addr_b, wr_addr;
   logic                 slot_ok;
   logic                 wr_en;
   logic [chce_pkg::PointWidth-1:0] rd_a, rd_b;
   chce_pkg::side_type   side;
   logic signed [31:0]   out_x, out_y, out_z;

   // Points-in-use register.
   always_comb begin
      points_in_use_in = csr_we ? csr_wdata : points_in_use_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         points_in_use_ff <= '0;
      end else begin
         points_in_use_ff <= points_in_use_in;
      end
   end

   // Effective point count, clamped to the table depth.
   always_comb begin
      n_ext       = 9'(points_in_use_ff);
      n_eff       = (n_ext > 9'(MAX_POINTS)) ? 9'(MAX_POINTS) : n_ext;
      short_curve = n_eff < 9'd2;
      divisor     = 8'(n_eff - 9'd1);
   end

   // The pipeline advances whenever the response register is free.
   assign ce         = !rsp_tvalid || rsp_tready;
   assign req_tready = ce;

   // Unpack the request payload.
   assign in_entry.pos_x = req_tdata[35:4];
   assign in_entry.pos_y = req_tdata[67:36];
   assign in_entry.pos_z = req_tdata[99:68];
   assign in_entry.tan_x = req_tdata[131:100];
   assign in_entry.tan_y = req_tdata[163:132];
   assign in_entry.tan_z = req_tdata[195:164];

   chce_front u_front (
      .clock         (clock),
      .reset         (reset),
      .ce            (ce),
      .in_valid      (req_tvalid),
      .in_mode       (req_tuser),
      .in_slot       (req_tdata[3:0]),
      .in_entry      (in_entry),
      .in_curve_time (req_tdata[219:196]),
      .divisor       (divisor),
      .out_valid     (f_valid),
      .out_mode      (f_mode),
      .out_slot      (f_slot),
      .out_entry     (f_entry),
      .out_basis     (f_basis),
      .seg_rem       (seg_rem)
   );

   // Table access: writes and reads happen at the same stage, in order.
   always_comb begin
      addr_a  = seg_rem[AddrWidth-1:0];
      addr_b  = AddrWidth'(addr_a + 1'b1);
      wr_addr = AddrWidth'(f_slot);
      slot_ok = 9'(f_slot) < 9'(MAX_POINTS);
      wr_en   = ce && f_valid && (f_mode == chce_pkg::ModeWrite) && slot_ok;
   end

   // Two copies of the table give the two neighbouring points in one read.
   chce_ram #(
      .WIDTH (chce_pkg::PointWidth),
      .DEPTH (MAX_POINTS)
   ) u_table_a (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (f_entry),
      .rd_en   (ce),
      .rd_addr (addr_a),
      .rd_data (rd_a)
   );

   chce_ram #(
      .WIDTH (chce_pkg::PointWidth),
      .DEPTH (MAX_POINTS)
   ) u_table_b (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (f_entry),
      .rd_en   (ce),
      .rd_addr (addr_b),
      .rd_data (rd_b)
   );

   // Result kind travels alongside the basis.
   always_comb begin
      side.valid = f_valid;
      side.basis = f_basis;
      if (f_mode == chce_pkg::ModeWrite) begin
         side.status = chce_pkg::StatusWrite;
      end else if (short_curve) begin
         side.status = chce_pkg::StatusShort;
      end else begin
         side.status = chce_pkg::StatusEval;
      end
   end

   chce_blend u_blend (
      .clock      (clock),
      .reset      (reset),
      .ce         (ce),
      .side_in    (side),
      .point_a    (chce_pkg::point_type'(rd_a)),
      .point_b    (chce_pkg::point_type'(rd_b)),
      .rsp_valid  (rsp_tvalid),
      .rsp_status (rsp_tuser),
      .rsp_x      (out_x),
      .rsp_y      (out_y),
      .rsp_z      (out_z)
   );

   assign rsp_tdata = {out_z, out_y, out_x};

   // A result that is not an evaluation carries zero coordinates.
   a_zero_unless_eval : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser != chce_pkg::StatusEval) |-> rsp_tdata == 96'd0)
      else $error("non-evaluation result with nonzero coordinates");

   // With fewer than two points no evaluation result may appear.
   a_short_no_eval : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && short_curve |-> rsp_tuser != chce_pkg::StatusEval)
      else $error("evaluation result on a curve shorter than two points");

   // Reset empties the response register.
   a_reset_clears : assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("response valid straight after reset");

   // The table is only written while the pipeline advances.
   a_write_on_advance : assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (!rsp_tvalid || rsp_tready) && f_valid)
      else $error("table write while the pipeline is held");

endmodule
`default_nettype wire

/* rtl/chce_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module chce_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port, held while not enabled.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

/* rtl/chce_front.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Curve evaluator front end
// Takes the curve time apart, works out the segment remainder two bits a
// stage and builds the Hermite basis weights over four register stages.
// ----------------------------------------------------------------------------
module chce_front (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      ce,
   input  wire logic                      in_valid,
   input  wire logic                      in_mode,
   input  wire logic [3:0]                in_slot,
   input  wire chce_pkg::point_type       in_entry,
   input  wire logic signed [23:0]        in_curve_time,
   input  wire logic [7:0]                divisor,
   output      logic                      out_valid,
   output      logic                      out_mode,
   output      logic [3:0]                out_slot,
   output      chce_pkg::point_type       out_entry,
   output      chce_pkg::basis_type       out_basis,
   output      logic [7:0]                seg_rem
);

   typedef struct packed {
      logic                valid;
      logic                mode;
      logic [3:0]          slot;
      chce_pkg::point_type entry;
      logic signed [23:0]  curve_time;
   } in_stage_type;

   typedef struct packed {
      logic                valid;
      logic                mode;
      logic [3:0]          slot;
      chce_pkg::point_type entry;
      logic [7:0]          ip;
      logic [7:0]          rem;
      logic [15:0]         p;
      logic [15:0]         p2;
      logic [15:0]         p3;
   } mid_stage_type;

   typedef struct packed {
      logic                valid;
      logic                mode;
      logic [3:0]          slot;
      chce_pkg::point_type entry;
      logic [7:0]          ip;
      logic [7:0]          rem;
      chce_pkg::basis_type basis;
   } basis_stage_type;

   in_stage_type    s1_ff, s1_in;
   mid_stage_type   s2_ff, s2_in;
   mid_stage_type   s3_ff, s3_in;
   basis_stage_type s4_ff, s4_in;

   logic [23:0]        mag;
   logic [31:0]        sq;
   logic [31:0]        cube;
   logic signed [19:0] p_s, p2_s, p3_s;

   // Stage 1: register the accepted transfer.
   always_comb begin
      s1_in = s1_ff;
      if (ce) begin
         s1_in.valid      = in_valid;
         s1_in.mode       = in_mode;
         s1_in.slot       = in_slot;
         s1_in.entry      = in_entry;
         s1_in.curve_time = in_curve_time;
      end
      if (reset) begin
         s1_in.valid = 1'b0;
      end
   end

   // Stage 2: magnitude, fraction square and the top two remainder bits.
   always_comb begin
      mag = s1_ff.curve_time[23] ? 24'(-s1_ff.curve_time) : 24'(s1_ff.curve_time);
      sq  = mag[15:0] * mag[15:0];
      s2_in = s2_ff;
      if (ce) begin
         s2_in.valid = s1_ff.valid;
         s2_in.mode  = s1_ff.mode;
         s2_in.slot  = s1_ff.slot;
         s2_in.entry = s1_ff.entry;
         s2_in.ip    = mag[23:16];
         s2_in.p     = mag[15:0];
         s2_in.p2    = sq[31:16];
         s2_in.p3    = '0;
         s2_in.rem   = chce_pkg::seg_step(chce_pkg::seg_step(8'd0, mag[23], divisor),
                                          mag[22], divisor);
      end
      if (reset) begin
         s2_in.valid = 1'b0;
      end
   end

   // Stage 3: fraction cube and the next two remainder bits.
   always_comb begin
      cube  = s2_ff.p2 * s2_ff.p;
      s3_in = s3_ff;
      if (ce) begin
         s3_in     = s2_ff;
         s3_in.p3  = cube[31:16];
         s3_in.rem = chce_pkg::seg_step(chce_pkg::seg_step(s2_ff.rem, s2_ff.ip[5], divisor),
                                        s2_ff.ip[4], divisor);
      end
      if (reset) begin
         s3_in.valid = 1'b0;
      end
   end

   // Stage 4: Hermite basis weights and two more remainder bits.
   always_comb begin
      p_s   = 20'($signed({4'd0, s3_ff.p}));
      p2_s  = 20'($signed({4'd0, s3_ff.p2}));
      p3_s  = 20'($signed({4'd0, s3_ff.p3}));
      s4_in = s4_ff;
      if (ce) begin
         s4_in.valid     = s3_ff.valid;
         s4_in.mode      = s3_ff.mode;
         s4_in.slot      = s3_ff.slot;
         s4_in.entry     = s3_ff.entry;
         s4_in.ip        = s3_ff.ip;
         s4_in.basis.h00 = 20'sd2 * p3_s - 20'sd3 * p2_s + 20'sd65536;
         s4_in.basis.h01 = 20'sd3 * p2_s - 20'sd2 * p3_s;
         s4_in.basis.h10 = p3_s - 20'sd2 * p2_s + p_s;
         s4_in.basis.h11 = p3_s - p2_s;
         s4_in.rem = chce_pkg::seg_step(chce_pkg::seg_step(s3_ff.rem, s3_ff.ip[3], divisor),
                                        s3_ff.ip[2], divisor);
      end
      if (reset) begin
         s4_in.valid = 1'b0;
      end
   end

   // Pipeline registers; only the valid bits are reset, in the next-state logic.
   always_ff @(posedge clock) begin
      s1_ff <= s1_in;
      s2_ff <= s2_in;
      s3_ff <= s3_in;
      s4_ff <= s4_in;
   end

   // The last two remainder bits feed the table address directly.
   assign seg_rem   = chce_pkg::seg_step(chce_pkg::seg_step(s4_ff.rem, s4_ff.ip[1], divisor),
                                         s4_ff.ip[0], divisor);
   assign out_valid = s4_ff.valid;
   assign out_mode  = s4_ff.mode;
   assign out_slot  = s4_ff.slot;
   assign out_entry = s4_ff.entry;
   assign out_basis = s4_ff.basis;

endmodule
`default_nettype wire

/* rtl/chce_blend.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Curve evaluator blend stages
// Weights the two control points with the basis, sums per axis and
// saturates into the response register.
// ----------------------------------------------------------------------------
module chce_blend (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                ce,
   input  wire chce_pkg::side_type  side_in,
   input  wire chce_pkg::point_type point_a,
   input  wire chce_pkg::point_type point_b,
   output      logic                rsp_valid,
   output      logic [1:0]          rsp_status,
   output      logic signed [31:0]  rsp_x,
   output      logic signed [31:0]  rsp_y,
   output      logic signed [31:0]  rsp_z
);

   typedef struct packed {
      logic       valid;
      logic [1:0] status;
   } ctl_type;

   typedef struct packed {
      logic               valid;
      logic [1:0]         status;
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [31:0] z;
   } out_type;

   chce_pkg::side_type side5_ff, side5_in;
   ctl_type            ctl6_ff, ctl6_in;
   out_type            out_ff, out_in;
   logic signed [35:0] term_ff [3][4];
   logic signed [35:0] term_in [3][4];

   logic signed [31:0] pa [3];
   logic signed [31:0] pb [3];
   logic signed [31:0] ta [3];
   logic signed [31:0] tb [3];
   logic signed [51:0] prod [3][4];
   logic signed [37:0] sum [3];
   logic signed [31:0] sat [3];

   // Stage 5: control word lines up with the table read data.
   always_comb begin
      side5_in = ce ? side_in : side5_ff;
      if (reset) begin
         side5_in.valid = 1'b0;
      end
   end

   // Stage 6: twelve products, each floored to Q16.
   always_comb begin
      pa[0] = point_a.pos_x;  pa[1] = point_a.pos_y;  pa[2] = point_a.pos_z;
      pb[0] = point_b.pos_x;  pb[1] = point_b.pos_y;  pb[2] = point_b.pos_z;
      ta[0] = point_a.tan_x;  ta[1] = point_a.tan_y;  ta[2] = point_a.tan_z;
      tb[0] = point_b.tan_x;  tb[1] = point_b.tan_y;  tb[2] = point_b.tan_z;
      ctl6_in = ctl6_ff;
      if (ce) begin
         ctl6_in.valid  = side5_ff.valid;
         ctl6_in.status = side5_ff.status;
      end
      if (reset) begin
         ctl6_in.valid = 1'b0;
      end
      for (int k = 0; k < 3; k++) begin
         prod[k][0] = 52'(side5_ff.basis.h00 * pa[k]);
         prod[k][1] = 52'(side5_ff.basis.h01 * pb[k]);
         prod[k][2] = 52'(side5_ff.basis.h10 * ta[k]);
         prod[k][3] = 52'(side5_ff.basis.h11 * tb[k]);
         for (int j = 0; j < 4; j++) begin
            term_in[k][j] = ce ? prod[k][j][51:16] : term_ff[k][j];
         end
      end
   end

   // Stage 7: per-axis sum and saturation into the response register.
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         sum[k] = 38'(term_ff[k][0]) + 38'(term_ff[k][1])
                + 38'(term_ff[k][2]) + 38'(term_ff[k][3]);
         if (sum[k] > 38'sd2147483647) begin
            sat[k] = 32'sh7FFFFFFF;
         end else if (sum[k] < -38'sd2147483648) begin
            sat[k] = 32'sh80000000;
         end else begin
            sat[k] = sum[k][31:0];
         end
      end
      out_in = out_ff;
      if (ce) begin
         out_in.valid  = ctl6_ff.valid;
         out_in.status = ctl6_ff.status;
         if (ctl6_ff.status == chce_pkg::StatusEval) begin
            out_in.x = sat[0];
            out_in.y = sat[1];
            out_in.z = sat[2];
         end else begin
            out_in.x = '0;
            out_in.y = '0;
            out_in.z = '0;
         end
      end
      if (reset) begin
         out_in.valid = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      side5_ff <= side5_in;
      ctl6_ff  <= ctl6_in;
      term_ff  <= term_in;
      out_ff   <= out_in;
   end

   assign rsp_valid  = out_ff.valid;
   assign rsp_status = out_ff.status;
   assign rsp_x      = out_ff.x;
   assign rsp_y      = out_ff.y;
   assign rsp_z      = out_ff.z;

endmodule
`default_nettype wire

/* tb/sv/cubic_hermite_curve_eval_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cubic Hermite curve evaluator: result checker
// Watches both channels and the configuration port, keeps its own copy of the
// point table, forms the expected result of each request transfer and
// compares every response transfer with the oldest one waiting.
// ----------------------------------------------------------------------------
module cubic_hermite_curve_eval_checker (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   input  wire logic         req_tready,
   input  wire logic [223:0] req_tdata,
   input  wire logic         req_tuser,
   input  wire logic         rsp_tvalid,
   input  wire logic         rsp_tready,
   input  wire logic [95:0]  rsp_tdata,
   input  wire logic [1:0]   rsp_tuser,
   input  wire logic         csr_we,
   input  wire logic [4:0]   csr_wdata,
   output int                fail_count,
   output int                pending_count
);

   typedef struct packed {
      logic [1:0]  status;
      logic [95:0] coords;
   } curve_result_type;

   localparam int PendDepth = 64;

   logic signed [31:0] point_mem [16][6];
   logic [4:0]         point_count;
   curve_result_type   pending_results [PendDepth];
   int                 push_count = 0;
   int                 pop_count = 0;

   // Truncate a Q32 product toward minus infinity.
   function automatic logic signed [63:0] floor16(input logic signed [63:0] v);
      return v >>> 16;
   endfunction

   // Work out the result one request transfer produces.
   function automatic curve_result_type blend_point(input logic [223:0] d,
                                                    input logic mode);
      curve_result_type r;
      logic signed [23:0] ct;
      logic [23:0] mag;
      logic signed [63:0] p, p2, p3, h00, h01, h10, h11, s;
      int n, seg, k;
      r = '0;
      if (mode == chce_pkg::ModeWrite) begin
         r.status = chce_pkg::StatusWrite;
         return r;
      end
      n = (point_count > 16) ? 16 : point_count;
      if (n < 2) begin
         r.status = chce_pkg::StatusShort;
         return r;
      end
      ct = d[219:196];
      mag = ct < 0 ? -ct : ct;
      p = mag[15:0];
      seg = (mag >> 16) % (n - 1);
      p2 = (p * p) >>> 16;
      p3 = (p2 * p) >>> 16;
      h00 = 2 * p3 - 3 * p2 + 65536;
      h01 = 3 * p2 - 2 * p3;
      h10 = p3 - 2 * p2 + p;
      h11 = p3 - p2;
      for (k = 0; k < 3; k++) begin
         s = floor16(h00 * point_mem[seg][k]) + floor16(h01 * point_mem[seg+1][k])
           + floor16(h10 * point_mem[seg][k+3]) + floor16(h11 * point_mem[seg+1][k+3]);
         if (s > 64'sd2147483647) s = 64'sd2147483647;
         if (s < -64'sd2147483648) s = -64'sd2147483648;
         r.coords[32*k +: 32] = s[31:0];
      end
      r.status = chce_pkg::StatusEval;
      return r;
   endfunction

   assign pending_count = push_count - pop_count;

   initial fail_count = 0;

   // Track configuration, predict on each request and check each response.
   always @(posedge clock) begin
      curve_result_type want;
      int k;
      if (reset) begin
         point_count <= '0;
      end else begin
         if (csr_we) begin
            point_count <= csr_wdata;
         end
         if (req_tvalid && req_tready) begin
            pending_results[push_count % PendDepth] = blend_point(req_tdata, req_tuser);
            push_count = push_count + 1;
            if (req_tuser == chce_pkg::ModeWrite) begin
               for (k = 0; k < 6; k++) begin
                  point_mem[req_tdata[3:0]][k] = req_tdata[4 + 32*k +: 32];
               end
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            if (push_count == pop_count) begin
               fail_count <= fail_count + 1;
               if (fail_count < 10) $display("Unexpected response transfer %h/%0d",
                                             rsp_tdata, rsp_tuser);
            end else begin
               want = pending_results[pop_count % PendDepth];
               pop_count = pop_count + 1;
               if (want.coords !== rsp_tdata || want.status !== rsp_tuser) begin
                  fail_count <= fail_count + 1;
                  if (fail_count < 10) $display("Mismatch: expected %h/%0d, got %h/%0d",
                                                want.coords, want.status,
                                                rsp_tdata, rsp_tuser);
               end
            end
         end
      end
   end
endmodule

/* tb/sv/cubic_hermite_curve_eval_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cubic Hermite curve evaluator: testbench top
// Drives writes of control points and curve evaluations over several point
// counts and idling patterns; the checker predicts and compares results.
// ----------------------------------------------------------------------------
module cubic_hermite_curve_eval_test;

   logic         clock = 0;
   logic         reset = 1;
   logic         req_tvalid = 0;
   logic         req_tready;
   logic [223:0] req_tdata = '0;
   logic         req_tuser = 0;
   logic         rsp_tvalid;
   logic         rsp_tready = 0;
   logic [95:0]  rsp_tdata;
   logic [1:0]   rsp_tuser;
   logic         csr_we = 0;
   logic [4:0]   csr_wdata = '0;
   int           fail_count, pending_count;
   int           send_idle_pct = 0, recv_stall_pct = 0;
   int           hold_cycles = 0;
   int           ph;

   always begin
      #2 clock = 1;
      #2 clock = 0;
   end

   cubic_hermite_curve_eval DUT (.*);

   cubic_hermite_curve_eval_checker checker_inst (.*);

   // Receiver: random stalls, plus a long hold-off when requested.
   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_tready <= 0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Offer one transfer and wait for its acceptance; valid stays high so
   // that the next transfer can follow without a gap.
   task automatic send_item(input logic mode, input logic [223:0] d);
      while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 0;
         @(negedge clock);
      end
      req_tuser <= mode;
      req_tdata <= d;
      req_tvalid <= 1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   function automatic logic [31:0] rand_coord();
      case ($urandom_range(5))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return $urandom_range(65536 * 4) - 65536 * 2;
         default: return $urandom;
      endcase
   endfunction

   task automatic write_point(input logic [3:0] slot);
      logic [223:0] d;
      int k;
      d = '0;
      d[3:0] = slot;
      for (k = 0; k < 6; k++) d[4 + 32*k +: 32] = rand_coord();
      d[219:196] = 24'($urandom);
      send_item(chce_pkg::ModeWrite, d);
   endtask

   task automatic eval_at(input logic [23:0] ct);
      logic [223:0] d;
      d = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      d[219:196] = ct;
      d[223:220] = '0;
      send_item(chce_pkg::ModeEval, d);
   endtask

   // Stop offering, wait until every result is in, then let the pipeline drain.
   task automatic drain();
      req_tvalid <= 0;
      @(negedge clock);
      while (pending_count != 0) @(negedge clock);
      repeat (10) @(negedge clock);
   endtask

   task automatic set_points(input logic [4:0] n);
      csr_wdata <= n;
      csr_we <= 1;
      @(negedge clock);
      csr_we <= 0;
   endtask

   // Random evaluations only touch written entries.
   task automatic eval_random();
      logic [23:0] ct;
      case ($urandom_range(7))
         0: ct = 24'h800000;
         1: ct = 24'h7fffff;
         2: ct = {8'($urandom_range(255)), 16'h0000};
         3: ct = {8'($urandom_range(255)), 16'hffff};
         default: ct = 24'($urandom);
      endcase
      eval_at(ct);
   endtask

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      @(negedge clock);
      // Directed: short curves, then all entries and extreme times.
      eval_at(24'h010000);
      write_point(0);
      drain();
      set_points(1);
      eval_at(24'h000000);
      drain();
      set_points(0);
      eval_at(24'h000000);
      for (int s = 1; s < 16; s++) write_point(s[3:0]);
      drain();
      set_points(16);
      eval_at(24'h000000);
      eval_at(24'h7fffff);
      eval_at(24'h800000);
      eval_at(24'h800001);
      eval_at(24'hff8000);
      eval_at(24'h0e8000);
      drain();
      set_points(31);
      eval_at(24'h0fffff);
      eval_at(24'h000001);
      // Random phases with different point counts and idling.
      for (ph = 0; ph < 8; ph++) begin
         drain();
         set_points(ph == 0 ? 5'd2 : ph == 7 ? 5'd31 : 5'($urandom_range(2, 20)));
         case (ph % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 88; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 88; end
            default: begin send_idle_pct = 12; recv_stall_pct = 12; end
         endcase
         if (ph == 4) hold_cycles = 60;
         for (int i = 0; i < 230; i++) begin
            if ($urandom_range(5) == 0) write_point(4'($urandom));
            else eval_random();
            if (ph == 5 && i == 100) drain();
         end
      end
      drain();
      repeat (20) @(negedge clock);
      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   // Guard against a hang.
   initial begin
      #4000000;
      $display("Test completed with failures");
      $finish;
   end
endmodule

/* cubic_hermite_curve_eval.f */
rtl/chce_pkg.sv
rtl/chce_ram.sv
rtl/chce_front.sv
rtl/chce_blend.sv
rtl/cubic_hermite_curve_eval.sv
tb/sv/cubic_hermite_curve_eval_checker.sv
tb/sv/cubic_hermite_curve_eval_test.sv
